[hw/rtl/ps2_scancode_to_char_assert.svh]
// assertion macros for the scancode translator
`ifndef PS2_SCANCODE_TO_CHAR_ASSERT_SVH
`define PS2_SCANCODE_TO_CHAR_ASSERT_SVH

// same-cycle implication, checked out of reset
`define PS2SC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define PS2SC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/ps2sc_pkg.sv]
`default_nettype none
package ps2sc_pkg;

  localparam int EXT_DEPTH  = 64;
  localparam int CASE_DEPTH = 128;

  // one shared table memory: extended, control, shifted, unshifted
  localparam int EXT_BASE   = 0;
  localparam int CTRL_BASE  = EXT_DEPTH;
  localparam int SHIFT_BASE = 2 * EXT_DEPTH;
  localparam int UNSH_BASE  = 2 * EXT_DEPTH + CASE_DEPTH;
  localparam int TBL_DEPTH  = 2 * (EXT_DEPTH + CASE_DEPTH);
  localparam int TBL_AW     = $clog2(TBL_DEPTH);

  localparam int IN_TDATA_W  = 32;
  localparam int OUT_TDATA_W = 24;

  localparam logic [7:0] CODE_BREAK  = 8'hF0;
  localparam logic [7:0] CODE_EXT    = 8'hE0;
  localparam logic [7:0] CODE_CTRL   = 8'h14;
  localparam logic [7:0] CODE_RSHIFT = 8'h59;
  localparam logic [7:0] CODE_NUM    = 8'h77;
  localparam logic [7:0] CODE_CAPS   = 8'h58;
  localparam logic [7:0] CODE_SCROLL = 8'h7E;
  localparam logic [7:0] CODE_ALT    = 8'h11;
  localparam logic [7:0] CODE_DEL    = 8'h71;

  localparam logic [1:0] TBL_EXT   = 2'd0;
  localparam logic [1:0] TBL_CTRL  = 2'd1;
  localparam logic [1:0] TBL_SHIFT = 2'd2;
  localparam logic [1:0] TBL_UNSH  = 2'd3;

  // key flag bit positions
  localparam int FLAG_SHIFT  = 0;
  localparam int FLAG_ALT    = 1;
  localparam int FLAG_CTRL   = 2;
  localparam int FLAG_NUM    = 4;
  localparam int FLAG_CAPS   = 5;
  localparam int FLAG_SCROLL = 6;
  localparam int FLAG_EXT    = 7;

  // led bit positions
  localparam int LED_SCROLL = 0;
  localparam int LED_NUM    = 1;
  localparam int LED_CAPS   = 2;

  typedef logic [TBL_AW-1:0] tbl_addr_t;

  typedef struct packed {
    logic       char_valid;
    logic       lookup;
    logic       led_changed;
    logic [2:0] led_bits;
    logic       reset_request;
    logic [7:0] modifier_bits;
  } ps2sc_res_t;

endpackage
`default_nettype wire

[hw/rtl/ps2sc_ram.sv]
`default_nettype none
module ps2sc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 384,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic             rd_en,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

[hw/rtl/ps2_scancode_to_char.sv]
// channel | dir | tuser     | tdata (lowest bit up)
// in_     | in  | func      | scancode, table_id, entry_index, entry_value
// out_    | out | -         | char_valid, char_code, led_changed, led_bits,
//         |     |           | reset_request, modifier_bits
//
// one beat accepted per cycle unless the output stalls; a result passes through the
// table memory's registered read and stage-one register, then the output register
// key state updates at acceptance, so the next beat sees it at once
// rst_n is synchronous; table contents are not cleared and must be loaded first
// a stalled output holds its beat; in_tready drops only when both stages are full
`default_nettype none
module ps2_scancode_to_char (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_tvalid,
  output logic                                  in_tready,
  // scancode[7:0], table_id[9:8], entry_index[16:10], entry_value[24:17]
  input  wire logic [ps2sc_pkg::IN_TDATA_W-1:0] in_tdata,
  // func[0]
  input  wire logic                             in_tuser,
  output logic                                  out_tvalid,
  input  wire logic                             out_tready,
  // char_valid[0], char_code[8:1], led_changed[9], led_bits[12:10],
  // reset_request[13], modifier_bits[21:14]
  output logic [ps2sc_pkg::OUT_TDATA_W-1:0]     out_tdata
);
  import ps2sc_pkg::*;

  logic       func;
  logic [7:0] sc;
  logic [1:0] tid;
  logic [6:0] idx;
  logic [7:0] val;

  logic       brk_r, brk_nxt;
  logic [7:0] flags_r, flags_nxt;
  logic [2:0] led_r, led_nxt;

  logic       s1_vld_r;
  ps2sc_res_t s1_r, s1_nxt;
  logic       out_vld_r;
  logic [OUT_TDATA_W-1:0] out_r;

  logic       in_fire, s1_adv;
  logic       wr_ok, wr_en, rd_en;
  tbl_addr_t  wr_addr, rd_addr;
  logic [7:0] rd_data;
  logic [7:0] char_code;

  assign func = in_tuser;
  assign sc   = in_tdata[7:0];
  assign tid  = in_tdata[9:8];
  assign idx  = in_tdata[16:10];
  assign val  = in_tdata[24:17];

  assign s1_adv    = s1_vld_r && (!out_vld_r || out_tready);
  assign in_tready = !s1_vld_r || s1_adv;
  assign in_fire   = in_tvalid && in_tready;

  always_comb begin
    brk_nxt   = brk_r;
    flags_nxt = flags_r;
    led_nxt   = led_r;
    s1_nxt    = '0;
    wr_ok     = 1'b0;
    wr_addr   = '0;
    rd_addr   = '0;
    if (func) begin
      unique case (tid)
        TBL_EXT: begin
          wr_ok   = {2'b0, idx} < 9'(EXT_DEPTH);
          wr_addr = TBL_AW'(EXT_BASE) + TBL_AW'(idx);
        end
        TBL_CTRL: begin
          wr_ok   = {2'b0, idx} < 9'(EXT_DEPTH);
          wr_addr = TBL_AW'(CTRL_BASE) + TBL_AW'(idx);
        end
        TBL_SHIFT: begin
          wr_ok   = {2'b0, idx} < 9'(CASE_DEPTH);
          wr_addr = TBL_AW'(SHIFT_BASE) + TBL_AW'(idx);
        end
        default: begin
          wr_ok   = {2'b0, idx} < 9'(CASE_DEPTH);
          wr_addr = TBL_AW'(UNSH_BASE) + TBL_AW'(idx);
        end
      endcase
    end else begin
      unique case (sc)
        CODE_BREAK: brk_nxt = 1'b1;
        CODE_EXT: flags_nxt[FLAG_EXT] = 1'b1;
        CODE_CTRL: begin
          flags_nxt[FLAG_CTRL] = !brk_r;
          brk_nxt = 1'b0;
        end
        CODE_RSHIFT: begin
          flags_nxt[FLAG_SHIFT] = !brk_r;
          brk_nxt = 1'b0;
        end
        CODE_ALT: begin
          flags_nxt[FLAG_ALT] = !brk_r;
          brk_nxt = 1'b0;
        end
        CODE_NUM: begin
          brk_nxt = 1'b0;
          if (!brk_r) begin
            flags_nxt[FLAG_NUM] = !flags_r[FLAG_NUM];
            led_nxt[LED_NUM]    = !led_r[LED_NUM];
            s1_nxt.led_changed  = 1'b1;
          end
        end
        CODE_CAPS: begin
          brk_nxt = 1'b0;
          if (!brk_r) begin
            flags_nxt[FLAG_CAPS] = !flags_r[FLAG_CAPS];
            led_nxt[LED_CAPS]    = !led_r[LED_CAPS];
            s1_nxt.led_changed   = 1'b1;
          end
        end
        CODE_SCROLL: begin
          brk_nxt = 1'b0;
          if (!brk_r) begin
            flags_nxt[FLAG_SCROLL] = !flags_r[FLAG_SCROLL];
            led_nxt[LED_SCROLL]    = !led_r[LED_SCROLL];
            s1_nxt.led_changed     = 1'b1;
          end
        end
        default: begin
          if (brk_r) begin
            brk_nxt = 1'b0;
          end else if (flags_r[FLAG_CTRL] && flags_r[FLAG_ALT] && sc == CODE_DEL) begin
            s1_nxt.reset_request = 1'b1;
          end else begin
            s1_nxt.char_valid = 1'b1;
            if (flags_r[FLAG_EXT]) begin
              flags_nxt[FLAG_EXT] = 1'b0;
              s1_nxt.lookup = {1'b0, sc} < 9'(EXT_DEPTH);
              rd_addr = TBL_AW'(EXT_BASE) + TBL_AW'(sc);
            end else if (flags_r[FLAG_CTRL]) begin
              s1_nxt.lookup = {1'b0, sc} < 9'(EXT_DEPTH);
              rd_addr = TBL_AW'(CTRL_BASE) + TBL_AW'(sc);
            end else if (flags_r[FLAG_SHIFT]) begin
              s1_nxt.lookup = {1'b0, sc} < 9'(CASE_DEPTH);
              rd_addr = TBL_AW'(SHIFT_BASE) + TBL_AW'(sc);
            end else begin
              s1_nxt.lookup = {1'b0, sc} < 9'(CASE_DEPTH);
              rd_addr = TBL_AW'(UNSH_BASE) + TBL_AW'(sc);
            end
          end
        end
      endcase
    end
    s1_nxt.led_bits      = led_nxt;
    s1_nxt.modifier_bits = flags_nxt;
  end

  assign wr_en = in_fire && func && wr_ok;
  assign rd_en = in_fire && s1_nxt.lookup;

  ps2sc_ram #(
    .WIDTH (8),
    .DEPTH (TBL_DEPTH)
  ) u_tbl (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (val),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      brk_r   <= 1'b0;
      flags_r <= '0;
      led_r   <= '0;
    end else if (in_fire) begin
      brk_r   <= brk_nxt;
      flags_r <= flags_nxt;
      led_r   <= led_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (in_tready) begin
      s1_vld_r <= in_fire;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_r <= s1_nxt;
    end
  end

  assign char_code = s1_r.lookup ? rd_data : 8'h00;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (!out_vld_r || out_tready) begin
      out_vld_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_r <= {2'b00, s1_r.modifier_bits, s1_r.reset_request, s1_r.led_bits,
                s1_r.led_changed, char_code, s1_r.char_valid};
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_r;

  `include "ps2_scancode_to_char_assert.svh"

  `PS2SC_ASSERT_NEXT(a_write_keeps_state, in_fire && in_tuser,
    $stable(flags_r) && $stable(led_r) && $stable(brk_r), "table write changed key state")
  `PS2SC_ASSERT_NEXT(a_led_toggle, in_fire && s1_nxt.led_changed,
    led_r != $past(led_r), "lock make left leds unchanged")
  `PS2SC_ASSERT_NOW(a_stall_full, !in_tready,
    s1_vld_r && out_vld_r && !out_tready, "input stalled with room in the pipe")

endmodule
`default_nettype wire
